// ===== rtl/ema_slope_peak_detector_defines.svh =====
// ----------------------------------------------------------------------------
// ema_slope_peak_detector_defines
// Assertion macros shared by the peak detector RTL. The checks compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EMA_SLOPE_PEAK_DETECTOR_DEFINES_SVH
`define EMA_SLOPE_PEAK_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define ESPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ESPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESPD_ASSERT(lbl, prop, msg)
`define ESPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/espd_pkg.sv =====
// ----------------------------------------------------------------------------
// espd_pkg
// Constants, register map and defaults of the smoothed-slope peak detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package espd_pkg;

  // Default geometry.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int INDEX_WIDTH_DEF  = 16;

  // Fixed field widths of the configuration registers.
  localparam int BETA_W  = 8;
  localparam int RUN_W   = 4;
  localparam int LIMIT_W = 16;

  // Run counters saturate at this value.
  localparam logic [RUN_W-1:0] CNT_MAX = 4'd15;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_BETA        = 2'd0,
    REG_RISE_RUN    = 2'd1,
    REG_FALL_RUN    = 2'd2,
    REG_SLOPE_LIMIT = 2'd3
  } cfg_reg_t;

  // Register reset values; beta of 38/256 is roughly 0.15.
  localparam logic [BETA_W-1:0]  BETA_RST     = 8'd38;
  localparam logic [RUN_W-1:0]   RISE_RUN_RST = 4'd3;
  localparam logic [RUN_W-1:0]   FALL_RUN_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd255;

endpackage

`default_nettype wire

// ===== rtl/ema_slope_peak_detector.sv =====
// ----------------------------------------------------------------------------
// ema_slope_peak_detector
// Exponential smoothing of a sample stream, slope tracking and peak reporting.
// ----------------------------------------------------------------------------
// Every sample item yields one result item. Items are accepted at one per
// clock while the output side is ready; an item is held in the input register
// until its result is written to the output register, which happens when that
// register is empty or being drained. The combinational filter update,
// acc + floor(-beta*(acc - sample)/256), feeds back into the accumulator and
// sets that rate. The smoothed value is the integer part of the accumulator;
// the slope is its change since the previous item, and a slope whose
// magnitude reaches slope_limit is replaced by the previous slope. A run of
// rise_run positive slopes arms the detector, and a following run of fall_run
// negative slopes marks a peak on tuser and disarms it. peak_index carries the
// item's index since reset on every result and wraps. Configuration should be
// written only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "ema_slope_peak_detector_defines.svh"

module ema_slope_peak_detector #(
  parameter int SAMPLE_WIDTH = espd_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = espd_pkg::FRAC_BITS_DEF,
  parameter int INDEX_WIDTH  = espd_pkg::INDEX_WIDTH_DEF,
  localparam int IN_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_FIELD_W = 2 * SAMPLE_WIDTH + 1 + INDEX_WIDTH,
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Sample stream.
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [IN_DATA_W-1:0]            in_tdata,   // sample
  // Result stream.
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [OUT_DATA_W-1:0]           out_tdata,  // smoothed, slope, peak_index
  output      logic                            out_tuser,  // peak_found
  // Configuration port.
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [espd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [espd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [espd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int ACC_W   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int PROD_W  = ACC_W + espd_pkg::BETA_W + 2;
  localparam int CMP_W   = ((SW > espd_pkg::LIMIT_W) ? SW : espd_pkg::LIMIT_W) + 1;
  localparam int RUN_W   = espd_pkg::RUN_W;

  // Configuration registers.
  logic [espd_pkg::BETA_W-1:0]  beta_r;
  logic [RUN_W-1:0]             rise_run_r;
  logic [RUN_W-1:0]             fall_run_r;
  logic [espd_pkg::LIMIT_W-1:0] slope_lim_r;

  // Input register.
  logic          s1_valid_r;
  logic [SW-1:0] s1_sample_r;

  // Result register.
  logic                   out_valid_r;
  logic [SW-1:0]          out_smooth_r;
  logic [SW:0]            out_slope_r;
  logic                   out_peak_r;
  logic [INDEX_WIDTH-1:0] out_index_r;

  // Detector state.
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [SW-1:0]          prev_smooth_r;
  logic [SW:0]            prev_slope_r;
  logic [RUN_W-1:0]       rise_cnt_r, rise_cnt_nxt;
  logic [RUN_W-1:0]       fall_cnt_r, fall_cnt_nxt;
  logic                   armed_r, armed_nxt;
  logic [INDEX_WIDTH-1:0] sample_cnt_r;
  logic                   seen_first_r;

  logic                   out_adv;
  logic                   load;
  logic                   cfg_wr;
  espd_pkg::cfg_reg_t     cfg_sel;

  logic signed [ACC_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic signed [PROD_W-1:0] acc_sum;
  logic [SW-1:0]            smooth_nxt;
  logic signed [SW:0]       delta;
  logic [SW:0]              mag;
  logic                     slope_ok;
  logic [SW:0]              slope_nxt;
  logic                     slope_pos;
  logic                     slope_neg;
  logic [RUN_W-1:0]         rise_inc;
  logic [RUN_W-1:0]         fall_inc;
  logic                     peak_nxt;

  // --------------------------------------------------------------------------
  // Handshake: the input register moves on whenever the result register is
  // empty or being drained in the same cycle.
  // --------------------------------------------------------------------------
  assign out_adv   = !out_valid_r || out_tready;
  assign load      = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_index_r, out_slope_r, out_smooth_r});
  assign out_tuser  = out_peak_r;

  // --------------------------------------------------------------------------
  // Configuration port.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = espd_pkg::cfg_reg_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_sel)
      espd_pkg::REG_BETA:        cfg_prdata = espd_pkg::CFG_DATA_W'(beta_r);
      espd_pkg::REG_RISE_RUN:    cfg_prdata = espd_pkg::CFG_DATA_W'(rise_run_r);
      espd_pkg::REG_FALL_RUN:    cfg_prdata = espd_pkg::CFG_DATA_W'(fall_run_r);
      espd_pkg::REG_SLOPE_LIMIT: cfg_prdata = espd_pkg::CFG_DATA_W'(slope_lim_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r      <= espd_pkg::BETA_RST;
      rise_run_r  <= espd_pkg::RISE_RUN_RST;
      fall_run_r  <= espd_pkg::FALL_RUN_RST;
      slope_lim_r <= espd_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        espd_pkg::REG_BETA:        beta_r      <= cfg_pwdata[espd_pkg::BETA_W-1:0];
        espd_pkg::REG_RISE_RUN:    rise_run_r  <= cfg_pwdata[RUN_W-1:0];
        espd_pkg::REG_FALL_RUN:    fall_run_r  <= cfg_pwdata[RUN_W-1:0];
        espd_pkg::REG_SLOPE_LIMIT: slope_lim_r <= cfg_pwdata[espd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Filter: floor((acc*(256-b) + S*b)/256) rewritten as acc + floor(-b*(acc-S)/256),
  // which needs one signed multiply and an arithmetic shift.
  // --------------------------------------------------------------------------
  always_comb begin
    diff    = $signed({1'b0, acc_r}) - $signed({1'b0, s1_sample_r, {FRAC_BITS{1'b0}}});
    prod    = PROD_W'(diff) * $signed({{(PROD_W - espd_pkg::BETA_W){1'b0}}, beta_r});
    step    = (-prod) >>> espd_pkg::BETA_W;
    acc_sum = $signed({{(PROD_W - ACC_W){1'b0}}, acc_r}) + step;
    acc_nxt = acc_sum[ACC_W-1:0];
  end

  assign smooth_nxt = acc_nxt[ACC_W-1:FRAC_BITS];

  // Slope with rejection of implausibly large jumps.
  always_comb begin
    delta     = $signed({1'b0, smooth_nxt}) - $signed({1'b0, prev_smooth_r});
    mag       = delta[SW] ? (SW + 1)'(-delta) : (SW + 1)'(delta);
    slope_ok  = CMP_W'(mag) < CMP_W'(slope_lim_r);
    if (!seen_first_r) begin
      slope_nxt = '0;
    end else if (slope_ok) begin
      slope_nxt = delta;
    end else begin
      slope_nxt = prev_slope_r;
    end
    slope_pos = !slope_nxt[SW] && (slope_nxt != '0);
    slope_neg = slope_nxt[SW];
  end

  // Arm on a run of rises, report on a run of falls after arming.
  always_comb begin
    rise_inc     = (rise_cnt_r == espd_pkg::CNT_MAX) ? rise_cnt_r : rise_cnt_r + 1'b1;
    fall_inc     = (fall_cnt_r == espd_pkg::CNT_MAX) ? fall_cnt_r : fall_cnt_r + 1'b1;
    rise_cnt_nxt = rise_cnt_r;
    fall_cnt_nxt = fall_cnt_r;
    armed_nxt    = armed_r;
    peak_nxt     = 1'b0;
    if (slope_pos && !armed_r) begin
      fall_cnt_nxt = '0;
      rise_cnt_nxt = rise_inc;
      if (rise_inc >= rise_run_r) begin
        armed_nxt = 1'b1;
      end
    end else if (slope_neg && armed_r) begin
      rise_cnt_nxt = '0;
      fall_cnt_nxt = fall_inc;
      if (fall_inc >= fall_run_r) begin
        peak_nxt  = 1'b1;
        armed_nxt = 1'b0;
      end
    end else if (slope_neg) begin
      rise_cnt_nxt = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= '0;
      prev_smooth_r <= '0;
      prev_slope_r <= '0;
      rise_cnt_r   <= '0;
      fall_cnt_r   <= '0;
      armed_r      <= 1'b0;
      sample_cnt_r <= '0;
      seen_first_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (load) begin
        acc_r         <= acc_nxt;
        prev_smooth_r <= smooth_nxt;
        prev_slope_r  <= slope_nxt;
        rise_cnt_r    <= rise_cnt_nxt;
        fall_cnt_r    <= fall_cnt_nxt;
        armed_r       <= armed_nxt;
        sample_cnt_r  <= sample_cnt_r + 1'b1;
        seen_first_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SW-1:0];
    end
    if (load) begin
      out_smooth_r <= smooth_nxt;
      out_slope_r  <= slope_nxt;
      out_peak_r   <= peak_nxt;
      out_index_r  <= sample_cnt_r;
    end
  end

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `ESPD_ASSERT(a_peak_on_fall, (out_valid_r && out_peak_r) |-> out_slope_r[SW], "peak on rise")
  `ESPD_ASSERT(a_disarm_by_peak, $fell(armed_r) |-> (out_valid_r && out_peak_r), "silent disarm")
  `ESPD_ASSERT(a_index_step, load |=> (sample_cnt_r == $past(sample_cnt_r) + 1'b1), "index skip")
  `ESPD_ASSERT(a_index_out, load |=> (out_index_r == $past(sample_cnt_r)), "wrong result index")
  `ESPD_ASSERT_ALWAYS(a_empty_ready, (rst_n && !out_valid_r) |-> in_tready, "stalled when empty")

endmodule

`default_nettype wire

// ===== tb/ema_slope_peak_detector_tb.sv =====
// ----------------------------------------------------------------------------
// ema_slope_peak_detector_tb
// Self-checking bench for the smoothed-slope peak detector. A short table of
// directed items and register writes comes first. Phases of shaped random
// waveforms follow under changing filter and run settings. An unbroken burst
// with the output always ready closes the run. Every result item is checked
// field by field against typed values or a predictor that runs alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ema_slope_peak_detector_tb;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 56;
  localparam int PLAN_LEN = 25;
  localparam int N_PHASES = 12;

  typedef struct packed {
    logic [15:0]        smoothed;
    logic signed [16:0] slope;
    logic               peak;
    logic [15:0]        index;
  } peak_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    espd_pkg::cfg_reg_t sel;
    logic [15:0]        value;
    bit                 known;
    peak_result_t       want;
  } plan_row_t;

  typedef enum logic [1:0] {SEG_RISE, SEG_FALL, SEG_HOLD, SEG_NOISE} seg_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata = '0;   // sample
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [OUT_W-1:0]                out_tdata;       // smoothed, slope, peak_index
  logic                            out_tuser;       // peak_found
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [espd_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [espd_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [espd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Predictor copy of the registers and the detector state.
  logic [espd_pkg::BETA_W-1:0]  beta_q8 = espd_pkg::BETA_RST;
  logic [espd_pkg::RUN_W-1:0]   rise_run = espd_pkg::RISE_RUN_RST;
  logic [espd_pkg::RUN_W-1:0]   fall_run = espd_pkg::FALL_RUN_RST;
  logic [espd_pkg::LIMIT_W-1:0] slope_limit = espd_pkg::LIMIT_RST;
  logic [23:0]                  flt_acc = '0;
  logic [15:0]                  prev_smooth = '0;
  logic signed [16:0]           prev_slope = '0;
  logic [espd_pkg::RUN_W-1:0]   rise_cnt = '0;
  logic [espd_pkg::RUN_W-1:0]   fall_cnt = '0;
  bit                           armed = 1'b0;
  logic [15:0]                  sample_idx = '0;
  bit                           seen_first = 1'b0;

  peak_result_t pending_results[$];
  peak_result_t want;
  int           n_errors = 0;
  int           n_accepted = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_stall_on = 1'b1;
  int           rx_stall_left = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd0, 1'b1, '{16'd0, 17'sd0, 1'b0, 16'd0}},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd65535, 1'b1, '{16'd9727, 17'sd0, 1'b0, 16'd1}},
    '{ROW_WRITE, espd_pkg::REG_BETA, 16'd255, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_SLOPE_LIMIT, 16'd65535, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_RISE_RUN, 16'd2, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_FALL_RUN, 16'd2, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd4000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd8000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd12000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd16000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd12000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd8000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd4000, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd0, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_SLOPE_LIMIT, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd65535, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd0, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_SLOPE_LIMIT, 16'd1, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_RISE_RUN, 16'd0, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_FALL_RUN, 16'd15, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd100, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd100, 1'b0, '0},
    '{ROW_WRITE, espd_pkg::REG_BETA, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, espd_pkg::REG_BETA, 16'd65535, 1'b0, '0}
  };

  ema_slope_peak_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return $urandom_range(1, 3);
    end else if (pick < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Filter update, slope selection and run tracking for one sample.
  function automatic peak_result_t smooth_and_detect(input logic [15:0] s);
    logic [39:0]        mix;
    logic signed [17:0] diff;
    logic [17:0]        mag;
    peak_result_t       r;
    mix = 40'(flt_acc) * (40'd256 - 40'(beta_q8)) + 40'({s, 8'h00}) * 40'(beta_q8);
    flt_acc = mix[31:8];
    r.smoothed = flt_acc[23:8];
    r.peak = 1'b0;
    r.index = sample_idx;
    if (!seen_first) begin
      r.slope = '0;
      seen_first = 1'b1;
    end else begin
      diff = $signed({2'b00, r.smoothed}) - $signed({2'b00, prev_smooth});
      mag = diff[17] ? 18'(-diff) : 18'(diff);
      r.slope = (mag < {2'b00, slope_limit}) ? diff[16:0] : prev_slope;
    end
    prev_slope = r.slope;
    prev_smooth = r.smoothed;
    if (r.slope > 0 && !armed) begin
      fall_cnt = '0;
      if (rise_cnt < espd_pkg::CNT_MAX) rise_cnt = rise_cnt + 1'b1;
      if (rise_cnt >= rise_run) armed = 1'b1;
    end else if (r.slope < 0 && armed) begin
      rise_cnt = '0;
      if (fall_cnt < espd_pkg::CNT_MAX) fall_cnt = fall_cnt + 1'b1;
      if (fall_cnt >= fall_run) begin
        r.peak = 1'b1;
        armed = 1'b0;
      end
    end else if (r.slope < 0) begin
      rise_cnt = '0;
    end
    sample_idx = sample_idx + 1'b1;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge after the gap.
  task automatic send_sample(input logic [15:0] s, input int gap, input bit typed_on,
                             input peak_result_t typed);
    peak_result_t r;
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    r = smooth_and_detect(s);
    pending_results.push_back(typed_on ? typed : r);
    n_accepted++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops the input side and lets every outstanding result come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input espd_pkg::cfg_reg_t sel, input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= espd_pkg::CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata <= espd_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (sel)
      espd_pkg::REG_BETA:        beta_q8 = value[espd_pkg::BETA_W-1:0];
      espd_pkg::REG_RISE_RUN:    rise_run = value[espd_pkg::RUN_W-1:0];
      espd_pkg::REG_FALL_RUN:    fall_run = value[espd_pkg::RUN_W-1:0];
      espd_pkg::REG_SLOPE_LIMIT: slope_limit = value[espd_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [16:0] exp_val,
                             input logic [16:0] act_val);
    if (exp_val !== act_val) begin
      n_errors++;
      if (n_errors <= 30) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
                 exp_val, act_val);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rx_stall_on || rx_stall_left == 0) begin
      out_tready <= 1'b1;
      if (rx_stall_on && $urandom_range(0, 4) == 0) rx_stall_left = idle_len();
    end else begin
      out_tready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 30) begin
          $display("%0t ns: result item with none expected, got 0x%0h", $time, out_tdata);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("smoothed", 17'(want.smoothed), 17'(out_tdata[15:0]));
        check_field("slope", 17'(want.slope), out_tdata[32:16]);
        check_field("peak_found", 17'(want.peak), 17'(out_tuser));
        check_field("peak_index", 17'(want.index), 17'(out_tdata[48:33]));
      end
    end
  end

  initial begin
    int          n_items;
    int          gap;
    int          lvl;
    int          seg_left;
    int          seg_step;
    int          waited;
    bit          fast;
    seg_mode_t   seg_mode;
    logic [15:0] b, r, f, l;
    lvl = 0;
    seg_left = 0;
    seg_step = 1;
    seg_mode = SEG_FALL;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        send_sample(plan[i].value, gap, plan[i].known, plan[i].want);
      end
    end

    // The last phase is an unbroken burst with no gaps and no stalls.
    for (int p = 0; p <= N_PHASES; p++) begin
      fast = (p == N_PHASES);
      wait_idle();
      case (p)
        0: begin b = 16'd255; r = 16'd1;  f = 16'd1;  l = 16'd65535; end
        1: begin b = 16'd0;   r = 16'd15; f = 16'd15; l = 16'd0;     end
        2: begin b = 16'd1;   r = 16'd15; f = 16'd15; l = 16'd1;     end
        3: begin b = 16'd128; r = 16'd0;  f = 16'd0;  l = 16'd65535; end
        N_PHASES: begin b = 16'd255; r = 16'd2; f = 16'd2; l = 16'd65535; end
        default: begin
          b = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(96, 255))
                                         : 16'($urandom_range(0, 255));
          r = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                          : 16'($urandom_range(1, 4));
          f = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                          : 16'($urandom_range(1, 4));
          case ($urandom_range(0, 2))
            0:       l = 16'd65535;
            1:       l = 16'($urandom_range(256, 8000));
            default: l = 16'($urandom_range(1, 65535));
          endcase
        end
      endcase
      write_reg(espd_pkg::REG_BETA, b);
      write_reg(espd_pkg::REG_RISE_RUN, r);
      write_reg(espd_pkg::REG_FALL_RUN, f);
      write_reg(espd_pkg::REG_SLOPE_LIMIT, l);
      tx_gaps_on = !fast && (p % 3 != 1);
      rx_stall_on = !fast && (p % 4 != 2);
      n_items = fast ? 120 : $urandom_range(90, 130);

      repeat (n_items) begin
        // Rising and falling ramps make up most of the stream; some noise.
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 20);
          seg_step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4000)
                                                 : $urandom_range(1, 300);
          case ($urandom_range(0, 9))
            0:       seg_mode = SEG_NOISE;
            1:       seg_mode = SEG_HOLD;
            default: seg_mode = (seg_mode == SEG_RISE) ? SEG_FALL : SEG_RISE;
          endcase
        end
        seg_left--;
        case (seg_mode)
          SEG_RISE:  lvl = lvl + seg_step;
          SEG_FALL:  lvl = lvl - seg_step;
          SEG_NOISE: lvl = $urandom_range(0, 65535);
          default: ;
        endcase
        if (lvl > 65535) lvl = 65535;
        if (lvl < 0) lvl = 0;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        send_sample(lvl[15:0], gap, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t ns: %0d expected result items never arrived", $time,
               pending_results.size());
    end
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t ns: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/espd_pkg.sv
rtl/ema_slope_peak_detector.sv
tb/ema_slope_peak_detector_tb.sv
